@@ rtl/swp_pkg.sv @@
// Package: shared constants, controller state type and command/status structs.
`timescale 1ns / 1ps
`default_nettype none
package swp_pkg;
  localparam int unsigned WINDOW_DEFAULT = 64;
  localparam int unsigned PCT_W          = 7;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned HELD_W         = 7;
  localparam int unsigned PCT_DIV        = 100;
  localparam logic [PCT_W-1:0] FIRST_PCT_RST  = 7'd50;
  localparam logic [PCT_W-1:0] SECOND_PCT_RST = 7'd95;
  localparam logic [PCT_W-1:0] THIRD_PCT_RST  = 7'd99;
  localparam logic [1:0] CFG_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SECOND = 2'd1;
  localparam logic [1:0] CFG_THIRD  = 2'd2;
  localparam logic       OP_RECORD  = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_SCAN,
    ST_PICK,
    ST_OUT
  } swp_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture item, update ring, start new pass
    logic rank_start; // compute target ranks
    logic scan_clr;   // reset scan pointer and tallies
    logic scan_step;  // compare one stored sample against the current candidate
    logic cand_next;  // advance candidate pointer
    logic pick;       // latch the candidate into each result whose rank matched
    logic out_load;   // move results into the output register
  } swp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;  // current scan element is the last one
    logic cand_last;  // current candidate is the last one
    logic empty;      // window holds no sample
  } swp_sts_t;
endpackage
`default_nettype wire

@@ rtl/swp_ctrl.sv @@
// Controller state machine sequencing the two-level scan over the window.
`timescale 1ns / 1ps
`default_nettype none
module swp_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  input  swp_pkg::swp_sts_t  sts,
  output swp_pkg::swp_cmd_t  cmd
);
  import swp_pkg::*;

  swp_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RANK;
      ST_RANK: state_nxt = sts.empty ? ST_OUT : ST_SCAN;
      ST_SCAN: if (sts.scan_last) state_nxt = ST_PICK;
      ST_PICK: state_nxt = sts.cand_last ? ST_OUT : ST_SCAN;
      ST_OUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RANK: begin
        cmd.rank_start = 1'b1;
        cmd.scan_clr   = 1'b1;
      end
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_PICK: begin
        cmd.pick      = 1'b1;
        cmd.cand_next = 1'b1;
        cmd.scan_clr  = 1'b1;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

@@ rtl/swp_dp.sv @@
// Datapath: sample ring memory, rank arithmetic, rank-count scan, output register.
`timescale 1ns / 1ps
`default_nettype none
module swp_dp #(
  parameter int unsigned WINDOW = swp_pkg::WINDOW_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  swp_pkg::swp_cmd_t                cmd,
  output swp_pkg::swp_sts_t                sts,
  input  wire                              cfg_we,
  input  wire [1:0]                        cfg_index,
  input  wire [swp_pkg::PCT_W-1:0]         cfg_data,
  input  wire                              in_op,
  input  wire [swp_pkg::DATA_W-1:0]        in_latency_us,
  output logic [swp_pkg::DATA_W-1:0]       out_first_value,
  output logic [swp_pkg::DATA_W-1:0]       out_second_value,
  output logic [swp_pkg::DATA_W-1:0]       out_third_value,
  output logic [swp_pkg::HELD_W-1:0]       out_samples_held
);
  import swp_pkg::*;

  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned PW = CW + PCT_W;
  localparam logic [CW-1:0] WIN_C = CW'(WINDOW);
  localparam logic [AW:0]   WIN_A = (AW + 1)'(WINDOW);
  // Divide by 100 through a reciprocal: floor(x*M >> SH) is exact for x < 2^PW.
  localparam int unsigned DIV_SH = PW + 7;
  localparam int unsigned DIV_MW = DIV_SH - 6;
  localparam logic [DIV_MW-1:0] DIV_M =
    DIV_MW'((64'd1 << DIV_SH) / 64'(PCT_DIV) + 64'd1);

  logic [DATA_W-1:0] mem [WINDOW];

  logic [PCT_W-1:0] pct_r [3];
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    oldest_r;
  logic [CW-1:0]    rank_r [3];
  logic [AW-1:0]    scan_r, cand_r;
  logic             scan_vld_r;
  logic [CW-1:0]    less_r, leq_r;
  logic [DATA_W-1:0] cand_val_r, scan_val_r;
  logic [DATA_W-1:0] res_r [3];
  logic [DATA_W-1:0] out_r [3];
  logic [HELD_W-1:0] held_r;

  // Ring address of logical position p (oldest first).
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                              input logic [AW-1:0] pos);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, pos};
    if (s >= WIN_A) s = s - WIN_A;
    return s[AW-1:0];
  endfunction

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] last_pos;
  always_comb begin
    wr_addr  = ring_addr(oldest_r, count_r[AW-1:0]);
    if (count_r == WIN_C) wr_addr = oldest_r;
    last_pos = AW'(count_r - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r[0] <= FIRST_PCT_RST;
      pct_r[1] <= SECOND_PCT_RST;
      pct_r[2] <= THIRD_PCT_RST;
      count_r  <= '0;
      oldest_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST:  pct_r[0] <= cfg_data;
          CFG_SECOND: pct_r[1] <= cfg_data;
          CFG_THIRD:  pct_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load && in_op == OP_RECORD) begin
        if (count_r != WIN_C) count_r <= count_r + CW'(1);
        else oldest_r <= ring_addr(oldest_r, AW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_op == OP_RECORD) mem[wr_addr] <= in_latency_us;
  end

  // Rank: floor(count*p/100) clamped to count-1.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.rank_start) begin
        logic [PW-1:0] prod;
        logic [PW-1:0] q;
        logic [PW+DIV_MW-1:0] scaled;
        prod   = PW'(count_r) * PW'(pct_r[k]);
        scaled = (PW + DIV_MW)'(prod) * (PW + DIV_MW)'(DIV_M);
        q      = PW'(scaled >> DIV_SH);
        if (q >= PW'(count_r)) rank_r[k] <= count_r - CW'(1);
        else rank_r[k] <= CW'(q);
      end
    end
  end

  // Outer loop picks a candidate, inner loop counts smaller/equal samples.
  // A candidate v sits at rank r when less(v) <= r < leq(v).
  always_ff @(posedge clk) begin
    if (cmd.load) cand_r <= '0;
    else if (cmd.cand_next) cand_r <= cand_r + AW'(1);
    if (cmd.scan_clr) begin
      scan_r     <= '0;
      less_r     <= '0;
      leq_r      <= '0;
      scan_vld_r <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_r     <= scan_r + AW'(1);
      scan_vld_r <= 1'b1;
      if (scan_vld_r) begin
        if (scan_val_r < cand_val_r)  less_r <= less_r + CW'(1);
        if (scan_val_r <= cand_val_r) leq_r  <= leq_r + CW'(1);
      end
    end
    cand_val_r <= mem[ring_addr(oldest_r, cand_r)];
    scan_val_r <= mem[ring_addr(oldest_r, scan_r)];
  end

  // One extra step drains the registered read of the last element.
  logic scan_done_r;
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) scan_done_r <= 1'b0;
    else if (cmd.scan_step && scan_r == last_pos) scan_done_r <= 1'b1;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.rank_start) res_r[k] <= '0;
      else if (cmd.pick && less_r <= rank_r[k] && rank_r[k] < leq_r)
        res_r[k] <= cand_val_r;
    end
    if (cmd.out_load) begin
      for (int k = 0; k < 3; k++) out_r[k] <= res_r[k];
      held_r <= HELD_W'(count_r);
    end
  end

  assign sts.scan_last = scan_done_r;
  assign sts.cand_last = (cand_r == last_pos);
  assign sts.empty     = (count_r == '0);

  assign out_first_value  = out_r[0];
  assign out_second_value = out_r[1];
  assign out_third_value  = out_r[2];
  assign out_samples_held = held_r;
endmodule
`default_nettype wire

@@ rtl/sliding_window_percentile.sv @@
// Top level: sliding-window percentile engine, controller plus datapath.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_op, in_latency_us
//  out     | output    | out_valid/ out_ready | first/second/third value, held
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// The scan loop dominates each transaction: every candidate sample is ranked
// by comparing it against every stored sample, one per cycle, followed by a
// drain step and a pick step. An empty window skips the scan entirely.
// Reset (rst_n low, synchronous) empties the window and restores 50/95/99.
// A result waits in the output register; a new transaction is taken once the
// previous result has been loaded into it.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_percentile #(
  parameter int unsigned WINDOW = swp_pkg::WINDOW_DEFAULT
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_op,
  input  wire [swp_pkg::DATA_W-1:0]   in_latency_us,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [swp_pkg::DATA_W-1:0]  out_first_value,
  output logic [swp_pkg::DATA_W-1:0]  out_second_value,
  output logic [swp_pkg::DATA_W-1:0]  out_third_value,
  output logic [swp_pkg::HELD_W-1:0]  out_samples_held,
  input  wire                         cfg_we,
  input  wire [1:0]                   cfg_index,
  input  wire [swp_pkg::PCT_W-1:0]    cfg_data
);
  import swp_pkg::*;

  swp_cmd_t cmd;
  swp_sts_t sts;

  // Controller: hold the item until the scan ends, then present the result.
  swp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: ring storage, rank math, compare scan and result registers.
  swp_dp #(.WINDOW(WINDOW)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_latency_us    (in_latency_us),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value),
    .out_third_value  (out_third_value),
    .out_samples_held (out_samples_held)
  );

  // Load and output-register update never coincide.
  a_no_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.out_load)) else $error("load and out_load overlap");
  // Sample count never exceeds the window.
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_samples_held <= HELD_W'(WINDOW) || WINDOW > 127))
    else $error("samples_held above window");
  // An accepted input is not followed by another accept in the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second transaction taken");
endmodule
`default_nettype wire
